### hdl/csq_pkg.sv
// csq_pkg: shared widths, limits, request, status and setting codes and the
// row store control bundle used by the continuity scan sequencer and its submodules
// no dependencies
package csq_pkg;

  localparam int MAX_PINS_DEF   = 64;
  localparam int MAX_CYCLES_DEF = 64;

  localparam int REQ_W      = 3;
  localparam int LEVEL_W    = 64;
  localparam int IDX_W      = 9;
  localparam int STATUS_W   = 2;
  localparam int SCAN_W     = 7;
  localparam int FIRST_W    = 6;
  localparam int INTERVAL_W = 16;
  localparam int BYTE_W     = 8;
  localparam int BIT_SEL_W  = 3;
  localparam int PIN_SEL_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // packed bit position: byte index times bits per byte plus bit in byte
  localparam int DVD_W = IDX_W + BIT_SEL_W;

  localparam int IN_DATA_W  = ((LEVEL_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = STATUS_W + SCAN_W + LEVEL_W + 1 + 1 + BYTE_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 3'd0,
    REQ_START = 3'd1,
    REQ_STOP  = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_READ  = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    RUN_IDLE   = 2'd0,
    RUN_ACTIVE = 2'd1,
    RUN_DONE   = 2'd2
  } run_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_PINS    = 2'd0,
    CFG_TOTAL       = 2'd1,
    CFG_FIRST_DRIVE = 2'd2,
    CFG_INTERVAL    = 2'd3
  } cfg_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clr;
  } mem_ctrl_t;

endpackage

### hdl/csq_row_mem.sv
// csq_row_mem: scan row store, one synchronous write and read port
// per-row valid bits give zero rows after reset and after a clear
// depends on csq_pkg
module csq_row_mem #(
  parameter int DEPTH = csq_pkg::MAX_CYCLES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  csq_pkg::mem_ctrl_t         ctrl_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [csq_pkg::LEVEL_W-1:0] wdata_i,
  output logic [csq_pkg::LEVEL_W-1:0] rdata_o
);
  import csq_pkg::*;

  logic [LEVEL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid_q;
  logic [LEVEL_W-1:0] rdata_q;
  logic               rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rvalid_q <= valid_q[addr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

### hdl/csq_divider.sv
// csq_divider: restoring divider, one quotient bit per cycle
// splits a packed bit position into row and pin; depends on csq_pkg
module csq_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [csq_pkg::DVD_W-1:0]  dividend_i,
  input  logic [csq_pkg::SCAN_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [csq_pkg::DVD_W-1:0]  quot_o,
  output logic [csq_pkg::SCAN_W-1:0] rem_o
);
  import csq_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DVD_W-1:0]   dvd_q;
  logic [SCAN_W-1:0]  rem_q;
  logic [SCAN_W-1:0]  div_q;
  logic [SCAN_W:0]    trial;
  logic               fits;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
      rem_q <= fits ? SCAN_W'(trial - {1'b0, div_q}) : trial[SCAN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

### hdl/continuity_scan_sequencer.sv
// continuity_scan_sequencer: harness continuity scan control and row readout
// top level; depends on csq_pkg, csq_row_mem and csq_divider
//
// usage: one request beat in, one result beat out. the request kind rides
// on s_axis_tuser (tick, start, stop, clear, read), the sampled pin levels
// and the byte index on s_axis_tdata. settings are written through the
// cfg port and are ignored while a scan is running.
// tick, start, stop and clear go from accept through S_EXEC and S_OUT to
// the result beat. a read goes from S_EXEC to the serial divider that
// turns the bit position into row and pin, then per bit through
// S_RD_ISSUE and S_RD_TAKE for the row store read, eight bits, then S_OUT.
// throughput: one request at a time; the next beat is taken as soon as
// the previous result sits in the output register.
// reset: idle, scan cycle zero, settings at their defaults, every stored
// row reads zero at once; clear also acts at once through row valid bits.
// a stalled receiver holds the result beat; one further request may be
// worked on and then waits until the output register frees up.
module continuity_scan_sequencer #(
  parameter int MAX_PINS   = csq_pkg::MAX_PINS_DEF,
  parameter int MAX_CYCLES = csq_pkg::MAX_CYCLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // cfg port
  input  logic                            cfg_we_i,
  input  logic [csq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [csq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pin_levels[63:0], byte_index[72:64], zero pad
  input  logic [csq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // req_type[2:0]
  input  logic [csq_pkg::REQ_W-1:0]       s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // run_state[1:0], scan_index[8:2], drive_mask[72:9], row_captured[73],
  // request_accepted[74], read_byte[82:75], zero pad
  output logic [csq_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import csq_pkg::*;

  localparam int AW = (MAX_CYCLES > 1) ? $clog2(MAX_CYCLES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_RD_ISSUE,
    S_RD_TAKE,
    S_OUT
  } state_e;

  // settings
  logic [SCAN_W-1:0]     num_pins_q;
  logic [SCAN_W-1:0]     total_q;
  logic [FIRST_W-1:0]    first_q;
  logic [INTERVAL_W-1:0] interval_q;

  // scan state
  state_e                state_q;
  run_e                  run_q;
  logic [SCAN_W-1:0]     scan_q;
  logic [INTERVAL_W-1:0] elapsed_q;

  // latched request
  req_e                  req_q;
  logic [LEVEL_W-1:0]    levels_q;
  logic [IDX_W-1:0]      idx_q;

  // per-request result
  logic                  cap_q;
  logic                  acc_q;
  logic [BYTE_W-1:0]     byte_q;

  // read walk
  logic [DVD_W-1:0]      row_q;
  logic [SCAN_W-1:0]     pin_q;
  logic [BIT_SEL_W-1:0]  bit_q;
  logic                  inrange_q;

  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic                  settings_ok;
  logic [LEVEL_W-1:0]    pin_mask;
  logic [LEVEL_W-1:0]    drive;
  logic [SCAN_W-1:0]     drive_off;
  logic [INTERVAL_W-1:0] elapsed_inc;
  logic                  tick_run;
  logic                  tick_end;
  logic                  tick_cap;
  logic [SCAN_W-1:0]     scan_inc;
  logic                  out_free;

  mem_ctrl_t             mem_ctrl;
  logic [AW-1:0]         mem_addr;
  logic [LEVEL_W-1:0]    mem_rdata;

  logic                  div_start;
  logic                  div_done;
  logic [DVD_W-1:0]      div_quot;
  logic [SCAN_W-1:0]     div_rem;
  logic                  row_in_range;
  logic                  pin_last;

  assign settings_ok = (num_pins_q != '0) && (32'(num_pins_q) <= 32'(MAX_PINS)) &&
                       (total_q != '0) && (32'(total_q) <= 32'(MAX_CYCLES)) &&
                       (interval_q != '0) && ({1'b0, first_q} < total_q);

  assign pin_mask = (num_pins_q >= SCAN_W'(LEVEL_W)) ? '1 :
                    ((LEVEL_W'(1) << num_pins_q) - LEVEL_W'(1));

  assign drive_off = scan_q - {1'b0, first_q};

  always_comb begin
    drive = '0;
    if (run_q == RUN_ACTIVE && scan_q >= {1'b0, first_q} &&
        drive_off < num_pins_q && drive_off < SCAN_W'(LEVEL_W)) begin
      drive = LEVEL_W'(1) << drive_off[PIN_SEL_W-1:0];
    end
  end

  // tick decisions
  assign tick_run    = (state_q == S_EXEC) && (req_q == REQ_TICK) && (run_q == RUN_ACTIVE);
  assign tick_end    = scan_q >= total_q;
  assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
  assign tick_cap    = tick_run && !tick_end &&
                       ((elapsed_inc >= interval_q) || (scan_q == '0));
  assign scan_inc    = scan_q + 1'b1;

  // row store access
  assign row_in_range = (row_q < DVD_W'(total_q)) && (32'(row_q) < 32'(MAX_CYCLES));

  always_comb begin
    mem_ctrl       = '0;
    mem_addr       = row_q[AW-1:0];
    mem_ctrl.wr_en = tick_cap && (32'(scan_q) < 32'(MAX_CYCLES));
    mem_ctrl.clr   = (state_q == S_EXEC) && (req_q == REQ_CLEAR);
    mem_ctrl.rd_en = (state_q == S_RD_ISSUE) && row_in_range;
    if (state_q == S_EXEC) begin
      mem_addr = AW'(scan_q);
    end
  end

  csq_row_mem #(
    .DEPTH (MAX_CYCLES),
    .AW    (AW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mem_ctrl),
    .addr_i  (mem_addr),
    .wdata_i (levels_q & pin_mask),
    .rdata_o (mem_rdata)
  );

  assign div_start = (state_q == S_EXEC) && (req_q == REQ_READ) && settings_ok;

  csq_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({idx_q, BIT_SEL_W'(0)}),
    .divisor_i  (num_pins_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign pin_last = (pin_q + 1'b1) == num_pins_q;
  assign out_free = !m_valid_q || m_axis_tready;

  // settings writes, ignored while a scan runs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_pins_q <= SCAN_W'(1);
      total_q    <= SCAN_W'(1);
      first_q    <= '0;
      interval_q <= INTERVAL_W'(1);
    end else if (cfg_we_i && run_q != RUN_ACTIVE) begin
      case (cfg_e'(cfg_idx_i))
        CFG_NUM_PINS:    num_pins_q <= cfg_data_i[SCAN_W-1:0];
        CFG_TOTAL:       total_q    <= cfg_data_i[SCAN_W-1:0];
        CFG_FIRST_DRIVE: first_q    <= cfg_data_i[FIRST_W-1:0];
        CFG_INTERVAL:    interval_q <= cfg_data_i[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q    <= req_e'(s_axis_tuser);
      levels_q <= s_axis_tdata[LEVEL_W-1:0];
      idx_q    <= s_axis_tdata[LEVEL_W +: IDX_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      run_q     <= RUN_IDLE;
      scan_q    <= '0;
      elapsed_q <= '0;
      cap_q     <= 1'b0;
      acc_q     <= 1'b0;
      byte_q    <= '0;
      row_q     <= '0;
      pin_q     <= '0;
      bit_q     <= '0;
      inrange_q <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cap_q   <= 1'b0;
            acc_q   <= 1'b0;
            byte_q  <= '0;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_OUT;
          case (req_q)
            REQ_TICK: begin
              if (run_q == RUN_ACTIVE) begin
                if (tick_end) begin
                  run_q <= RUN_DONE;
                end else if (tick_cap) begin
                  cap_q     <= 1'b1;
                  elapsed_q <= '0;
                  scan_q    <= scan_inc;
                  if (scan_inc >= total_q) begin
                    run_q <= RUN_DONE;
                  end
                end else begin
                  elapsed_q <= elapsed_inc;
                end
              end
            end
            REQ_START: begin
              if (run_q != RUN_ACTIVE && settings_ok) begin
                scan_q    <= '0;
                elapsed_q <= '0;
                run_q     <= RUN_ACTIVE;
                acc_q     <= 1'b1;
              end
            end
            REQ_STOP: begin
              if (run_q == RUN_ACTIVE) begin
                run_q <= RUN_IDLE;
                acc_q <= 1'b1;
              end
            end
            REQ_CLEAR: begin
              scan_q <= '0;
              acc_q  <= 1'b1;
            end
            REQ_READ: begin
              acc_q <= 1'b1;
              if (settings_ok) begin
                state_q <= S_DIV;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            row_q   <= div_quot;
            pin_q   <= div_rem;
            bit_q   <= '0;
            state_q <= S_RD_ISSUE;
          end
        end
        S_RD_ISSUE: begin
          inrange_q <= row_in_range;
          state_q   <= S_RD_TAKE;
        end
        S_RD_TAKE: begin
          byte_q[bit_q] <= inrange_q & mem_rdata[pin_q[PIN_SEL_W-1:0]];
          if (pin_last) begin
            pin_q <= '0;
            row_q <= row_q + 1'b1;
          end else begin
            pin_q <= pin_q + 1'b1;
          end
          bit_q <= bit_q + 1'b1;
          if (bit_q == '1) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_RD_ISSUE;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= OUT_DATA_W'({byte_q, acc_q, cap_q, drive, scan_q, run_q});
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### bench/continuity_scan_sequencer_tb.sv
`timescale 1ns / 100ps
// continuity_scan_sequencer_tb: random and directed request beats into the scan sequencer,
// every result beat predicted from a behavioral copy of the scan state and checked in order
// depends on csq_pkg and the continuity_scan_sequencer rtl
module continuity_scan_sequencer_tb;
  import csq_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int END_SETTLE      = 64;
  localparam int MAX_REPORTS     = 10;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int BITS_PER_BYTE   = 8;
  localparam int MAX_BYTE_INDEX  = (1 << IDX_W) - 1;

  typedef enum int {SET_WIDEST, SET_NARROWEST, SET_RANDOM, SET_BROKEN} setting_kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0]   read_byte;
    logic                accepted;
    logic                captured;
    logic [LEVEL_W-1:0]  drive_mask;
    logic [SCAN_W-1:0]   scan_index;
    logic [STATUS_W-1:0] run_state;
  } scan_report_t;

  class scan_scoreboard;
    logic [LEVEL_W-1:0]    rows [MAX_CYCLES_DEF];
    logic [SCAN_W-1:0]     cycle;
    run_e                  status;
    logic [INTERVAL_W-1:0] elapsed;
    logic [SCAN_W-1:0]     num_pins;
    logic [SCAN_W-1:0]     total_cycles;
    logic [FIRST_W-1:0]    first_drive;
    logic [INTERVAL_W-1:0] interval;
    scan_report_t          reports_due[$];
    int unsigned           mismatches;

    function new();
      foreach (rows[r]) rows[r] = '0;
      cycle        = '0;
      status       = RUN_IDLE;
      elapsed      = '0;
      num_pins     = SCAN_W'(1);
      total_cycles = SCAN_W'(1);
      first_drive  = '0;
      interval     = INTERVAL_W'(1);
      mismatches   = 0;
    endfunction

    function bit settings_ok();
      return num_pins >= 1 && num_pins <= MAX_PINS_DEF &&
             total_cycles >= 1 && total_cycles <= MAX_CYCLES_DEF &&
             interval >= 1 && first_drive < total_cycles;
    endfunction

    function logic [LEVEL_W-1:0] pin_mask();
      if (num_pins >= LEVEL_W) return '1;
      return (64'd1 << num_pins) - 64'd1;
    endfunction

    function logic [LEVEL_W-1:0] drive_now();
      int unsigned d;
      if (status != RUN_ACTIVE || cycle < first_drive) return '0;
      d = cycle - first_drive;
      if (d >= num_pins || d >= LEVEL_W) return '0;
      return 64'd1 << d;
    endfunction

    function logic [BYTE_W-1:0] packed_byte(logic [IDX_W-1:0] idx);
      int unsigned g;
      int unsigned row;
      int unsigned pin;
      logic [BYTE_W-1:0] b;
      b = '0;
      if (!settings_ok()) return '0;
      for (int k = 0; k < BITS_PER_BYTE; k++) begin
        g   = int'(idx) * BITS_PER_BYTE + k;
        row = g / num_pins;
        pin = g % num_pins;
        if (row < total_cycles && row < MAX_CYCLES_DEF) b[k] = rows[row][pin];
      end
      return b;
    endfunction

    function void write_setting(cfg_e idx, logic [CFG_DATA_W-1:0] data);
      if (status == RUN_ACTIVE) return;
      case (idx)
        CFG_NUM_PINS:    num_pins     = data[SCAN_W-1:0];
        CFG_TOTAL:       total_cycles = data[SCAN_W-1:0];
        CFG_FIRST_DRIVE: first_drive  = data[FIRST_W-1:0];
        CFG_INTERVAL:    interval     = data[INTERVAL_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [LEVEL_W-1:0] levels,
                               logic [IDX_W-1:0] idx);
      scan_report_t rep;
      rep = '0;
      case (kind)
        REQ_TICK: begin
          if (status == RUN_ACTIVE) begin
            if (cycle >= total_cycles) begin
              status = RUN_DONE;
            end else begin
              if (elapsed != '1) elapsed = elapsed + 1'b1;
              if (elapsed >= interval || cycle == 0) begin
                if (cycle < MAX_CYCLES_DEF) rows[cycle] = levels & pin_mask();
                rep.captured = 1'b1;
                elapsed      = '0;
                cycle        = cycle + 1'b1;
                if (cycle >= total_cycles) status = RUN_DONE;
              end
            end
          end
        end
        REQ_START: begin
          if (status != RUN_ACTIVE && settings_ok()) begin
            cycle        = '0;
            elapsed      = '0;
            status       = RUN_ACTIVE;
            rep.accepted = 1'b1;
          end
        end
        REQ_STOP: begin
          if (status == RUN_ACTIVE) begin
            status       = RUN_IDLE;
            rep.accepted = 1'b1;
          end
        end
        REQ_CLEAR: begin
          foreach (rows[r]) rows[r] = '0;
          cycle        = '0;
          rep.accepted = 1'b1;
        end
        REQ_READ: begin
          rep.read_byte = packed_byte(idx);
          rep.accepted  = 1'b1;
        end
        default: ;
      endcase
      rep.run_state  = status;
      rep.scan_index = cycle;
      rep.drive_mask = drive_now();
      reports_due.insert(reports_due.size(), rep);
    endfunction

    function void check_result(scan_report_t got);
      scan_report_t exp;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result beat with nothing expected: %p", got);
        return;
      end
      exp = reports_due.pop_front();
      if (got.run_state !== exp.run_state || got.scan_index !== exp.scan_index ||
          got.drive_mask !== exp.drive_mask || got.captured !== exp.captured ||
          got.accepted !== exp.accepted || got.read_byte !== exp.read_byte) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch at %0t", $realtime);
          $display("  exp state %0d index %0d drive %h captured %b accepted %b byte %h",
                   exp.run_state, exp.scan_index, exp.drive_mask, exp.captured,
                   exp.accepted, exp.read_byte);
          $display("  got state %0d index %0d drive %h captured %b accepted %b byte %h",
                   got.run_state, got.scan_index, got.drive_mask, got.captured,
                   got.accepted, got.read_byte);
        end
      end
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  scan_scoreboard sb;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    items_sent    = 0;
  int unsigned    quiet_cycles  = 0;

  continuity_scan_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result beats are checked before request beats of the same edge are noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(scan_report_t'(m_axis_tdata[OUT_RAW_W-1:0]));
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tuser, s_axis_tdata[LEVEL_W-1:0],
                        s_axis_tdata[LEVEL_W +: IDX_W]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [LEVEL_W-1:0] levels,
                              input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_DATA_W'({idx, levels});
    s_axis_tuser  = kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (sb.reports_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // bits above the register width carry noise and must be dropped
  task automatic write_register(input cfg_e idx, input int unsigned value);
    int unsigned w;
    logic [CFG_DATA_W-1:0] data;
    w = (idx == CFG_INTERVAL) ? INTERVAL_W : (idx == CFG_FIRST_DRIVE) ? FIRST_W : SCAN_W;
    data = CFG_DATA_W'(value) | (CFG_DATA_W'($urandom) & ~CFG_DATA_W'((32'd1 << w) - 1));
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    sb.write_setting(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_settings(input int unsigned pins, input int unsigned cycles,
                                input int unsigned first, input int unsigned span);
    drain_results();
    write_register(CFG_NUM_PINS, pins);
    write_register(CFG_TOTAL, cycles);
    write_register(CFG_FIRST_DRIVE, first);
    write_register(CFG_INTERVAL, span);
  endtask

  function automatic logic [LEVEL_W-1:0] random_levels();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_byte_index();
    int unsigned nbytes;
    nbytes = (int'(sb.num_pins) * int'(sb.total_cycles) + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
    if (nbytes > MAX_BYTE_INDEX) nbytes = MAX_BYTE_INDEX;
    if ($urandom_range(9) == 0) return IDX_W'($urandom_range(MAX_BYTE_INDEX));
    return IDX_W'($urandom_range(nbytes));
  endfunction

  task automatic run_session(input int unsigned n_items, input bit noisy);
    int unsigned r;
    logic [REQ_W-1:0] kind;
    repeat (n_items) begin
      r = $urandom_range(99);
      kind = REQ_READ;
      if (sb.status == RUN_ACTIVE) begin
        if (!noisy)     kind = (r < 85) ? REQ_TICK : REQ_READ;
        else if (r < 70) kind = REQ_TICK;
        else if (r < 82) kind = REQ_READ;
        else if (r < 88) kind = REQ_STOP;
        else if (r < 93) kind = REQ_CLEAR;
        else if (r < 97) kind = REQ_START;
        else             kind = REQ_W'($urandom_range(MAX_BYTE_INDEX, REQ_READ + 1) & 3'h7);
      end else begin
        if (r < 35)      kind = REQ_START;
        else if (r < 75) kind = REQ_READ;
        else if (r < 85) kind = REQ_TICK;
        else if (r < 90) kind = REQ_CLEAR;
        else if (r < 95) kind = REQ_STOP;
        else             kind = REQ_W'($urandom_range({REQ_W{1'b1}}, REQ_READ + 1));
      end
      send_request(kind, random_levels(), pick_byte_index());
    end
  endtask

  task automatic configure_and_scan(input setting_kind_e how);
    int unsigned pins;
    int unsigned cycles;
    int unsigned first;
    int unsigned span;
    int unsigned n_items;
    pins   = ($urandom_range(9) == 0) ? 1 : ($urandom_range(9) == 0) ? MAX_PINS_DEF :
             $urandom_range(MAX_PINS_DEF, 1);
    cycles = ($urandom_range(9) == 0) ? 1 : ($urandom_range(9) == 0) ? MAX_CYCLES_DEF :
             $urandom_range(12, 1);
    first  = ($urandom_range(3) == 0) ? cycles - 1 : $urandom_range(cycles - 1);
    case ($urandom_range(19))
      0: span = (1 << INTERVAL_W) - 1;
      1: span = $urandom_range(20, 4);
      default: span = $urandom_range(3, 1);
    endcase
    case (how)
      SET_WIDEST: begin
        pins   = MAX_PINS_DEF;
        cycles = MAX_CYCLES_DEF;
        first  = MAX_CYCLES_DEF - 1;
        span   = 1;
      end
      SET_NARROWEST: begin
        pins   = 1;
        cycles = 1;
        first  = 0;
        span   = 1;
      end
      SET_BROKEN: begin
        case ($urandom_range(5))
          0: pins   = 0;
          1: pins   = $urandom_range((1 << SCAN_W) - 1, MAX_PINS_DEF + 1);
          2: cycles = 0;
          3: cycles = $urandom_range((1 << SCAN_W) - 1, MAX_CYCLES_DEF + 1);
          4: span   = 0;
          default: begin
            cycles = $urandom_range(12, 1);
            first  = $urandom_range((1 << FIRST_W) - 1, cycles);
          end
        endcase
      end
      default: ;
    endcase
    if (sb.status == RUN_ACTIVE && $urandom_range(4) != 0)
      send_request(REQ_STOP, random_levels(), '0);
    apply_settings(pins, cycles, first, span);
    n_items = cycles * span + cycles;
    if (n_items > 110) n_items = 110;
    run_session(16 + n_items, (how == SET_WIDEST) ? 1'b0 : ($urandom_range(9) < 3));
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned sessions;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 14;
    recv_idle_pct = 62;

    // reset settings: one pin, one cycle, drive at cycle zero
    send_request(REQ_READ, '0, '0);
    send_request(REQ_READ, '1, IDX_W'(MAX_BYTE_INDEX));
    send_request(REQ_TICK, '1, '0);
    send_request(REQ_STOP, '0, '0);
    send_request(REQ_W'(REQ_READ + 1), '0, '0);
    send_request({REQ_W{1'b1}}, '1, '1);
    send_request(REQ_START, '0, '0);
    send_request(REQ_START, '0, '0);
    send_request(REQ_TICK, '1, '0);
    send_request(REQ_TICK, '1, '0);
    send_request(REQ_READ, '0, '0);
    send_request(REQ_START, '0, '0);
    send_request(REQ_CLEAR, '0, '0);
    send_request(REQ_TICK, '0, '0);
    send_request(REQ_STOP, '0, '0);

    // no pins in use: start refused, reads give zero
    apply_settings(0, 1, 0, 1);
    send_request(REQ_START, '0, '0);
    send_request(REQ_READ, '0, '0);

    // widest pins, longest interval
    apply_settings(MAX_PINS_DEF, 2, 1, (1 << INTERVAL_W) - 1);
    send_request(REQ_START, '0, '0);
    send_request(REQ_TICK, {$urandom, $urandom}, '0);
    send_request(REQ_TICK, {$urandom, $urandom}, '0);
    send_request(REQ_TICK, '1, '0);
    send_request(REQ_READ, '0, '0);
    send_request(REQ_READ, '0, IDX_W'(7));
    send_request(REQ_STOP, '0, '0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = items_sent;
      sessions    = 0;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        if (sessions == 0)                 configure_and_scan(SET_WIDEST);
        else if (sessions == 1)            configure_and_scan(SET_NARROWEST);
        else if ($urandom_range(4) == 0)   configure_and_scan(SET_BROKEN);
        else                               configure_and_scan(SET_RANDOM);
        sessions++;
      end
    end

    s_axis_tvalid = 1'b0;
    while (sb.reports_due.size() != 0) @(negedge clk_i);
    repeat (END_SETTLE) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.reports_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/csq_pkg.sv
hdl/csq_row_mem.sv
hdl/csq_divider.sv
hdl/continuity_scan_sequencer.sv
bench/continuity_scan_sequencer_tb.sv
